>>> rtl/core/rpac_pkg.sv
// Package for the point rotation core: payload structs, datapath widths,
// CORDIC arctangent table and register map. No dependencies.
`timescale 1ns / 1ps

package rpac_pkg;

  // Coordinate format, fixed by the payload fields (signed Q12.4)
  localparam int COORD_BITS      = 16;
  localparam int GUARD_BITS      = 36 - COORD_BITS;
  localparam int DIFF_W          = COORD_BITS + 1;
  localparam int ACC_W           = DIFF_W + GUARD_BITS + 3;
  localparam int Z_W             = 34;
  localparam int ANGLE_W         = 16;
  localparam int PHI_W           = ANGLE_W + 1;
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int ROTATION_STAGES = 16;

  // Gain compensation: 0.60725293500888 in Q24, then shift out Q24 and guard bits
  localparam int GAIN_W      = 24;
  localparam int GAIN_Q24    = 10188014;
  localparam int ROUND_SHIFT = 24 + GUARD_BITS;
  localparam int LO_W        = GUARD_BITS;
  localparam int HI_W        = ACC_W - LO_W;
  localparam int PHI_W_PROD  = HI_W + GAIN_W + 1;
  localparam int PLO_W       = LO_W + GAIN_W;
  localparam int SUM_W       = PHI_W_PROD + LO_W + 1;
  localparam int RES_W       = SUM_W - ROUND_SHIFT;
  localparam int SAT_W       = RES_W + 1;

  localparam logic signed [PHI_W-1:0] QUARTER_TURN = PHI_W'(16384);

  // atan(2^-i) in units of 2^32 per turn
  localparam logic [31:0] ATAN_TURN32 [ANGLE_TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Configuration register map, word index
  localparam int CFG_ADDR_W = 4;
  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_ANGLE    = 2'd2
  } rpac_reg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
  } rpac_point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] rotated_x;
    logic signed [COORD_BITS-1:0] rotated_y;
  } rpac_result_t;

  // Data handed from cell to cell along the rotation chain
  typedef struct packed {
    logic                    vld;
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [Z_W-1:0]   z;
  } rpac_lane_t;

endpackage

>>> rtl/core/rpac_prerot.sv
// Entry stage of the rotation chain: center offset, guard-bit scaling and
// quarter-turn pre-rotation. Depends on rpac_pkg.
`timescale 1ns / 1ps

module rpac_prerot (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   take,
  input  rpac_pkg::rpac_point_t                  point,
  input  logic signed [rpac_pkg::COORD_BITS-1:0] center_x,
  input  logic signed [rpac_pkg::COORD_BITS-1:0] center_y,
  input  logic [rpac_pkg::ANGLE_W-1:0]           angle,
  output rpac_pkg::rpac_lane_t                   lane_o
);

  logic signed [rpac_pkg::DIFF_W-1:0] dx, dy;
  logic signed [rpac_pkg::ACC_W-1:0]  xs, ys;
  logic signed [rpac_pkg::PHI_W-1:0]  phi, phi_adj;
  logic [rpac_pkg::ANGLE_W-1:0]       neg_angle;
  rpac_pkg::rpac_lane_t               lane_nxt, lane_r;

  always_comb begin
    dx = $signed({point.point_x[rpac_pkg::COORD_BITS-1], point.point_x})
       - $signed({center_x[rpac_pkg::COORD_BITS-1], center_x});
    dy = $signed({point.point_y[rpac_pkg::COORD_BITS-1], point.point_y})
       - $signed({center_y[rpac_pkg::COORD_BITS-1], center_y});
    xs = rpac_pkg::ACC_W'($signed({dx, {rpac_pkg::GUARD_BITS{1'b0}}}));
    ys = rpac_pkg::ACC_W'($signed({dy, {rpac_pkg::GUARD_BITS{1'b0}}}));

    // Rotate by minus the angle, as a signed half-turn value
    neg_angle = rpac_pkg::ANGLE_W'(-angle);
    phi       = rpac_pkg::PHI_W'($signed(neg_angle));

    lane_nxt.vld = take;
    lane_nxt.x   = xs;
    lane_nxt.y   = ys;
    phi_adj      = phi;
    if (phi > rpac_pkg::QUARTER_TURN) begin
      lane_nxt.x = -ys;
      lane_nxt.y = xs;
      phi_adj    = phi - rpac_pkg::QUARTER_TURN;
    end else if (phi < -rpac_pkg::QUARTER_TURN) begin
      lane_nxt.x = ys;
      lane_nxt.y = -xs;
      phi_adj    = phi + rpac_pkg::QUARTER_TURN;
    end
    lane_nxt.z = rpac_pkg::Z_W'($signed({phi_adj, 16'h0000}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.vld <= 1'b0;
    end else begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

>>> rtl/core/rpac_cell.sv
// One CORDIC micro-rotation cell of the rotation chain.
// Depends on rpac_pkg.
`timescale 1ns / 1ps

module rpac_cell #(
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rpac_pkg::rpac_lane_t lane_i,
  output rpac_pkg::rpac_lane_t lane_o
);

  localparam logic signed [rpac_pkg::Z_W-1:0] ATAN_STEP =
    rpac_pkg::Z_W'($signed({1'b0, rpac_pkg::ATAN_TURN32[STAGE]}));

  logic signed [rpac_pkg::ACC_W-1:0] xs, ys;
  rpac_pkg::rpac_lane_t              lane_nxt, lane_r;

  always_comb begin
    // Arithmetic shift rounds toward minus infinity
    xs = lane_i.x >>> STAGE;
    ys = lane_i.y >>> STAGE;
    lane_nxt.vld = lane_i.vld;
    if (!lane_i.z[rpac_pkg::Z_W-1]) begin
      lane_nxt.x = lane_i.x - ys;
      lane_nxt.y = lane_i.y + xs;
      lane_nxt.z = lane_i.z - ATAN_STEP;
    end else begin
      lane_nxt.x = lane_i.x + ys;
      lane_nxt.y = lane_i.y - xs;
      lane_nxt.z = lane_i.z + ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.vld <= 1'b0;
    end else begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

>>> rtl/core/rpac_finish.sv
// Exit stages: CORDIC gain compensation by split multiply, rounding,
// center add and saturation. Depends on rpac_pkg.
`timescale 1ns / 1ps

module rpac_finish (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  rpac_pkg::rpac_lane_t                   lane_i,
  input  logic signed [rpac_pkg::COORD_BITS-1:0] center_x,
  input  logic signed [rpac_pkg::COORD_BITS-1:0] center_y,
  output logic                                   out_valid,
  output rpac_pkg::rpac_result_t                 out_data
);

  localparam logic signed [rpac_pkg::GAIN_W:0] GAIN_S =
    (rpac_pkg::GAIN_W + 1)'(rpac_pkg::GAIN_Q24);
  localparam logic [rpac_pkg::GAIN_W-1:0] GAIN_U = rpac_pkg::GAIN_W'(rpac_pkg::GAIN_Q24);
  localparam logic signed [rpac_pkg::SUM_W-1:0] ROUND_HALF =
    rpac_pkg::SUM_W'(1) <<< (rpac_pkg::ROUND_SHIFT - 1);
  localparam logic signed [rpac_pkg::SAT_W-1:0] SAT_HI =
    rpac_pkg::SAT_W'((64'sd1 <<< (rpac_pkg::COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [rpac_pkg::SAT_W-1:0] SAT_LO =
    rpac_pkg::SAT_W'(-(64'sd1 <<< (rpac_pkg::COORD_BITS - 1)));

  logic signed [rpac_pkg::ACC_W-1:0]      acc      [2];
  logic signed [rpac_pkg::COORD_BITS-1:0] ctr      [2];
  logic signed [rpac_pkg::PHI_W_PROD-1:0] p_hi_nxt [2];
  logic signed [rpac_pkg::PHI_W_PROD-1:0] p_hi_r   [2];
  logic [rpac_pkg::PLO_W-1:0]             p_lo_nxt [2];
  logic [rpac_pkg::PLO_W-1:0]             p_lo_r   [2];
  logic signed [rpac_pkg::SUM_W-1:0]      sum      [2];
  logic signed [rpac_pkg::RES_W-1:0]      res_nxt  [2];
  logic signed [rpac_pkg::RES_W-1:0]      res_r    [2];
  logic signed [rpac_pkg::SAT_W-1:0]      tot      [2];
  logic signed [rpac_pkg::COORD_BITS-1:0] sat_nxt  [2];
  logic [2:0]                             vld_r;
  rpac_pkg::rpac_result_t                 data_r;

  always_comb begin
    acc[0] = lane_i.x;
    acc[1] = lane_i.y;
    ctr[0] = center_x;
    ctr[1] = center_y;
    for (int k = 0; k < 2; k++) begin
      // Split multiply: signed high part and unsigned low part
      p_hi_nxt[k] = $signed(acc[k][rpac_pkg::ACC_W-1:rpac_pkg::LO_W]) * GAIN_S;
      p_lo_nxt[k] = rpac_pkg::PLO_W'(acc[k][rpac_pkg::LO_W-1:0]) * rpac_pkg::PLO_W'(GAIN_U);
      // Recombine, round half up, shift out the fraction
      sum[k] = (rpac_pkg::SUM_W'(p_hi_r[k]) <<< rpac_pkg::LO_W)
             + $signed(rpac_pkg::SUM_W'(p_lo_r[k])) + ROUND_HALF;
      res_nxt[k] = rpac_pkg::RES_W'(sum[k] >>> rpac_pkg::ROUND_SHIFT);
      tot[k] = rpac_pkg::SAT_W'(res_r[k]) + rpac_pkg::SAT_W'(ctr[k]);
      if (tot[k] > SAT_HI) begin
        sat_nxt[k] = rpac_pkg::COORD_BITS'(SAT_HI);
      end else if (tot[k] < SAT_LO) begin
        sat_nxt[k] = rpac_pkg::COORD_BITS'(SAT_LO);
      end else begin
        sat_nxt[k] = rpac_pkg::COORD_BITS'(tot[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], lane_i.vld};
    end
  end

  always_ff @(posedge clk) begin
    p_hi_r           <= p_hi_nxt;
    p_lo_r           <= p_lo_nxt;
    res_r            <= res_nxt;
    data_r.rotated_x <= sat_nxt[0];
    data_r.rotated_y <= sat_nxt[1];
  end

  assign out_valid = vld_r[2];
  assign out_data  = data_r;

endmodule

>>> rtl/core/rotate_point_about_center_core.sv
// Top level of the point rotation core: APB register file, entry stage,
// chain of CORDIC cells and exit stages. Depends on rpac_pkg and submodules.
//
// Usage:
//  - Input channel: a point transaction (in_point) is taken at each rising
//    edge where start is high and busy is low. busy is never raised, so one
//    point may be issued in every cycle, back to back.
//  - Result channel: each point yields exactly one result transaction,
//    out_result, shown for one cycle with out_valid high. The receiver has
//    no way to stall; results come out in issue order.
//  - Pipeline from start to out_valid: one entry stage, the registered
//    CORDIC cells, then three exit stages for the split gain multiply,
//    rounding and center add/saturate.
//  - Throughput: one point per cycle, set by the fully pipelined cell chain.
//  - Configuration: APB writes to center_x (0x0), center_y (0x4) and
//    rotation_angle (0x8); change them only while no point is in flight.
//  - Reset (rst_n low, synchronous): the configuration registers go to
//    zero and all in-flight transactions are dropped.
`timescale 1ns / 1ps

module rotate_point_about_center_core #(
  parameter int ROTATION_STAGES = rpac_pkg::ROTATION_STAGES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // point input
  input  logic                              start,
  output logic                              busy,
  input  rpac_pkg::rpac_point_t             in_point,
  // result output
  output logic                              out_valid,
  output rpac_pkg::rpac_result_t            out_result,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rpac_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic signed [rpac_pkg::COORD_BITS-1:0] center_x_r;
  logic signed [rpac_pkg::COORD_BITS-1:0] center_y_r;
  logic [rpac_pkg::ANGLE_W-1:0]           angle_r;
  logic                                   cfg_wr;
  rpac_pkg::rpac_reg_t                    cfg_sel;
  rpac_pkg::rpac_lane_t                   chain [ROTATION_STAGES+1];

  // The chain accepts a point in every cycle
  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Register file: write on the APB access phase
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = rpac_pkg::rpac_reg_t'(paddr[rpac_pkg::CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      angle_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        rpac_pkg::REG_CENTER_X: center_x_r <= pwdata[rpac_pkg::COORD_BITS-1:0];
        rpac_pkg::REG_CENTER_Y: center_y_r <= pwdata[rpac_pkg::COORD_BITS-1:0];
        rpac_pkg::REG_ANGLE:    angle_r    <= pwdata[rpac_pkg::ANGLE_W-1:0];
        default: begin
          // unmapped word: drop the write
        end
      endcase
    end
  end

  // Read back, centers sign-extended, angle zero-extended
  always_comb begin
    case (cfg_sel)
      rpac_pkg::REG_CENTER_X: prdata = 32'($signed(center_x_r));
      rpac_pkg::REG_CENTER_Y: prdata = 32'($signed(center_y_r));
      rpac_pkg::REG_ANGLE:    prdata = 32'(angle_r);
      default:                prdata = '0;
    endcase
  end

  // Entry stage: offset from center and quarter-turn pre-rotation
  rpac_prerot u_prerot (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (start & ~busy),
    .point    (in_point),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .angle    (angle_r),
    .lane_o   (chain[0])
  );

  // Chain of micro-rotation cells, one per CORDIC iteration
  for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_cell
    rpac_cell #(
      .STAGE (g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .lane_i (chain[g]),
      .lane_o (chain[g+1])
    );
  end

  // Exit stages: gain compensation, rounding, center add and saturation
  rpac_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane_i    (chain[ROTATION_STAGES]),
    .center_x  (center_x_r),
    .center_y  (center_y_r),
    .out_valid (out_valid),
    .out_data  (out_result)
  );

endmodule
